@@ hw/rtl/fxa_pkg.sv @@
// Shared types, constants and helpers for the fixed-point ALU.
// No dependencies; used by every module of the block.
package fxa_pkg;

  localparam int DataW    = 32;
  localparam int MaxWidth = 32;
  localparam int DivBits  = 65;
  localparam int WidthW   = 7;
  localparam int FracW    = 6;
  localparam int ShiftW   = 7;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    RND_ZERO = 2'd0,
    RND_EVEN = 2'd1,
    RND_POS  = 2'd2,
    RND_NEG  = 2'd3
  } rnd_t;

  typedef enum logic [1:0] {
    CFG_INT_BITS  = 2'd0,
    CFG_FRAC_BITS = 2'd1,
    CFG_RND_MODE  = 2'd2,
    CFG_NONE      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [WidthW-1:0] width;
    logic [FracW-1:0]  frac;
    rnd_t              mode;
  } fxa_cfg_t;

  typedef struct packed {
    logic             valid;
    func_t            func;
    logic             neg;
    logic             invalid;
    logic             dz;
    logic [DataW-1:0] addsub;
  } fxa_sb_t;

  function automatic logic [DataW-1:0] width_mask(input logic [WidthW-1:0] w);
    logic [DataW-1:0] m;
    if (w >= WidthW'(DataW)) begin
      m = '1;
    end else begin
      m = (DataW'(1) << w[4:0]) - DataW'(1);
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/fxa_prep.sv @@
// Front end: operand masking, magnitudes, add/subtract, then product and dividend.
// Depends on fxa_pkg.
module fxa_prep
  import fxa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  fxa_cfg_t            cfg,
  input  logic                in_take,
  input  func_t               in_func,
  input  logic [DataW-1:0]    in_a,
  input  logic [DataW-1:0]    in_b,
  output fxa_sb_t             sb_out,
  output logic [DivBits-1:0]  value_out,
  output logic [DataW-1:0]    mb_out
);

  logic [DataW-1:0]  mask;
  logic [DataW-1:0]  a_m, b_m, ma, mb;
  logic [4:0]        wm1;
  logic              sa, sb;
  fxa_sb_t           sb1_nxt, sb1_r, sb2_r;
  logic [DataW-1:0]  ma1_r, mb1_r, mb2_r;
  logic [2*DataW-1:0] prod;
  logic [DivBits-1:0] dividend, value2_r;
  logic [ShiftW-1:0] sh;

  always_comb begin
    mask = width_mask(cfg.width);
    wm1  = 5'(cfg.width - WidthW'(1));
    a_m  = in_a & mask;
    b_m  = in_b & mask;
    sa   = a_m[wm1];
    sb   = b_m[wm1];
    ma   = sa ? ((~a_m + DataW'(1)) & mask) : a_m;
    mb   = sb ? ((~b_m + DataW'(1)) & mask) : b_m;
    sb1_nxt.valid   = in_take;
    sb1_nxt.func    = in_func;
    sb1_nxt.neg     = sa ^ sb;
    sb1_nxt.invalid = (cfg.width == '0) || (cfg.width > WidthW'(MaxWidth));
    sb1_nxt.dz      = (in_func == FUNC_DIV) && (mb == '0);
    sb1_nxt.addsub  = ((in_func == FUNC_SUB) ? (a_m - b_m) : (a_m + b_m)) & mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb1_r.valid <= 1'b0;
    end else begin
      sb1_r.valid <= sb1_nxt.valid;
    end
    sb1_r.func    <= sb1_nxt.func;
    sb1_r.neg     <= sb1_nxt.neg;
    sb1_r.invalid <= sb1_nxt.invalid;
    sb1_r.dz      <= sb1_nxt.dz;
    sb1_r.addsub  <= sb1_nxt.addsub;
    ma1_r         <= ma;
    mb1_r         <= mb;
  end

  always_comb begin
    prod     = {{DataW{1'b0}}, ma1_r} * {{DataW{1'b0}}, mb1_r};
    sh       = ShiftW'(DivBits) - cfg.width;
    dividend = {{(DivBits-DataW){1'b0}}, ma1_r} << sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb2_r.valid <= 1'b0;
    end else begin
      sb2_r.valid <= sb1_r.valid;
    end
    sb2_r.func    <= sb1_r.func;
    sb2_r.neg     <= sb1_r.neg;
    sb2_r.invalid <= sb1_r.invalid;
    sb2_r.dz      <= sb1_r.dz;
    sb2_r.addsub  <= sb1_r.addsub;
    value2_r      <= (sb1_r.func == FUNC_DIV) ? dividend : {1'b0, prod};
    mb2_r         <= mb1_r;
  end

  assign sb_out    = sb2_r;
  assign value_out = value2_r;
  assign mb_out    = mb2_r;

endmodule

@@ hw/rtl/fxa_div_stage.sv @@
// One restoring-divide step: shift in one dividend bit, compare, subtract; other functions pass through unchanged.
// Depends on fxa_pkg.
module fxa_div_stage
  import fxa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  fxa_sb_t            sb_in,
  input  logic [DivBits-1:0] value_in,
  input  logic [DataW-1:0]   rem_in,
  input  logic [DataW-1:0]   mb_in,
  output fxa_sb_t            sb_out,
  output logic [DivBits-1:0] value_out,
  output logic [DataW-1:0]   rem_out,
  output logic [DataW-1:0]   mb_out
);

  logic [DataW+1:0]   diff;
  logic               ge, act;
  logic [DivBits-1:0] value_nxt, value_r;
  logic [DataW-1:0]   rem_nxt, rem_r, mb_r;
  fxa_sb_t            sb_r;

  always_comb begin
    act  = (sb_in.func == FUNC_DIV);
    diff = {1'b0, rem_in, value_in[DivBits-1]} - {2'b00, mb_in};
    ge   = !diff[DataW+1];
    if (act) begin
      value_nxt = {value_in[DivBits-2:0], ge};
      rem_nxt   = ge ? diff[DataW-1:0] : {rem_in[DataW-2:0], value_in[DivBits-1]};
    end else begin
      value_nxt = value_in;
      rem_nxt   = rem_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r.valid <= 1'b0;
    end else begin
      sb_r.valid <= sb_in.valid;
    end
    sb_r.func    <= sb_in.func;
    sb_r.neg     <= sb_in.neg;
    sb_r.invalid <= sb_in.invalid;
    sb_r.dz      <= sb_in.dz;
    sb_r.addsub  <= sb_in.addsub;
    value_r      <= value_nxt;
    rem_r        <= rem_nxt;
    mb_r         <= mb_in;
  end

  assign sb_out    = sb_r;
  assign value_out = value_r;
  assign rem_out   = rem_r;
  assign mb_out    = mb_r;

endmodule

@@ hw/rtl/fxa_round.sv @@
// Back end: align, guard and sticky, then round, sign, select and mask.
// Depends on fxa_pkg.
module fxa_round
  import fxa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  fxa_cfg_t           cfg,
  input  fxa_sb_t            sb_in,
  input  logic [DivBits-1:0] value_in,
  output logic               out_valid,
  output logic [DataW-1:0]   out_result,
  output logic               out_dz
);

  logic [ShiftW-1:0]  s, sm1, rs;
  logic [DivBits-1:0] shifted, gsh, lowmask;
  logic               guard, sticky;
  fxa_sb_t            sb_r;
  logic [DataW-1:0]   ip_r;
  logic               guard_r, sticky_r;
  logic               up;
  logic [DataW-1:0]   mag, res, mask, sel;
  logic               valid_r, dz_r;
  logic [DataW-1:0]   result_r;

  always_comb begin
    rs      = ShiftW'(DivBits) - cfg.width - ShiftW'(cfg.frac);
    s       = (sb_in.func == FUNC_DIV) ? rs : ShiftW'(cfg.frac);
    sm1     = s - ShiftW'(1);
    shifted = value_in >> s;
    gsh     = value_in >> sm1;
    lowmask = (DivBits'(1) << sm1) - DivBits'(1);
    guard   = (s != '0) && gsh[0];
    sticky  = (s != '0) && (|(value_in & lowmask));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r.valid <= 1'b0;
    end else begin
      sb_r.valid <= sb_in.valid;
    end
    sb_r.func    <= sb_in.func;
    sb_r.neg     <= sb_in.neg;
    sb_r.invalid <= sb_in.invalid;
    sb_r.dz      <= sb_in.dz;
    sb_r.addsub  <= sb_in.addsub;
    ip_r         <= shifted[DataW-1:0];
    guard_r      <= guard;
    sticky_r     <= sticky;
  end

  always_comb begin
    unique case (cfg.mode)
      RND_EVEN: up = guard_r && (sticky_r || ip_r[0]);
      RND_POS:  up = !sb_r.neg && (guard_r || sticky_r);
      RND_NEG:  up = sb_r.neg && (guard_r || sticky_r);
      default:  up = 1'b0;
    endcase
    mag  = ip_r + DataW'(up);
    res  = sb_r.neg ? (~mag + DataW'(1)) : mag;
    mask = width_mask(cfg.width);
    if (sb_r.invalid) begin
      sel = '0;
    end else begin
      case (sb_r.func) inside
        FUNC_ADD, FUNC_SUB: sel = sb_r.addsub;
        FUNC_MUL:           sel = res & mask;
        default:            sel = sb_r.dz ? '0 : (res & mask);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= sb_r.valid;
    end
    result_r <= sel;
    dz_r     <= !sb_r.invalid && (sb_r.func == FUNC_DIV) && sb_r.dz;
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;
  assign out_dz     = dz_r;

endmodule

@@ hw/rtl/fixed_point_alu_rounding.sv @@
// Top level of the signed fixed-point ALU with selectable rounding.
// Depends on fxa_pkg, fxa_prep, fxa_div_stage and fxa_round.
//
// Usage:
//   Command channel: drive in_func, in_operand_a, in_operand_b with start high;
//   the word is taken on any edge where busy is low. busy never rises, so one
//   word may be issued every cycle.
//   Result channel: out_valid pulses for one cycle with out_result and
//   out_div_by_zero. Results leave in issue order, after two front stages,
//   65 divide steps (one quotient bit per stage) and two rounding stages.
//   Every operation travels the same path, so throughput is one word per
//   cycle for all functions.
//   Config channel: cfg_valid/cfg_ready (ready always high) with cfg_index and
//   cfg_data; write only with the pipeline drained.
//   Reset: synchronous, active low; clears all stage valid bits and loads the
//   A.B format 16.16 with truncation toward zero.
//   The receiver cannot stall; the pipeline always advances.
module fixed_point_alu_rounding
  import fxa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_func,
  input  logic [DataW-1:0] in_operand_a,
  input  logic [DataW-1:0] in_operand_b,
  output logic             out_valid,
  output logic [DataW-1:0] out_result,
  output logic             out_div_by_zero,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [FracW-1:0] cfg_data
);

  logic [FracW-1:0] int_bits_r, frac_bits_r;
  rnd_t             mode_r;
  fxa_cfg_t         cfg;

  fxa_sb_t            sb_c  [DivBits+1];
  logic [DivBits-1:0] val_c [DivBits+1];
  logic [DataW-1:0]   rem_c [DivBits+1];
  logic [DataW-1:0]   mb_c  [DivBits+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_bits_r  <= FracW'(16);
      frac_bits_r <= FracW'(16);
      mode_r      <= RND_ZERO;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INT_BITS:  int_bits_r  <= cfg_data;
        CFG_FRAC_BITS: frac_bits_r <= cfg_data;
        CFG_RND_MODE:  mode_r      <= rnd_t'(cfg_data[1:0]);
        default:       ;
      endcase
    end
  end

  always_comb begin
    cfg.width = WidthW'(int_bits_r) + WidthW'(frac_bits_r);
    cfg.frac  = frac_bits_r;
    cfg.mode  = mode_r;
  end

  fxa_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_take   (start && !busy),
    .in_func   (func_t'(in_func)),
    .in_a      (in_operand_a),
    .in_b      (in_operand_b),
    .sb_out    (sb_c[0]),
    .value_out (val_c[0]),
    .mb_out    (mb_c[0])
  );

  assign rem_c[0] = '0;

  for (genvar i = 0; i < DivBits; i++) begin : g_div
    fxa_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .sb_in     (sb_c[i]),
      .value_in  (val_c[i]),
      .rem_in    (rem_c[i]),
      .mb_in     (mb_c[i]),
      .sb_out    (sb_c[i+1]),
      .value_out (val_c[i+1]),
      .rem_out   (rem_c[i+1]),
      .mb_out    (mb_c[i+1])
    );
  end

  fxa_round u_round (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .sb_in      (sb_c[DivBits]),
    .value_in   (val_c[DivBits]),
    .out_valid  (out_valid),
    .out_result (out_result),
    .out_dz     (out_div_by_zero)
  );

endmodule
